[design/method_descriptor_checker_assert.svh]
// Assertion macros for the checker file of method_descriptor_checker.
// Depends on nothing; included by mdc_checker.sv.
`ifndef METHOD_DESCRIPTOR_CHECKER_ASSERT_SVH
`define METHOD_DESCRIPTOR_CHECKER_ASSERT_SVH

// same-cycle implication
`define MDC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("method_descriptor_checker: same-cycle check failed");

// next-cycle implication
`define MDC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("method_descriptor_checker: next-cycle check failed");

`endif

[design/mdc_pkg.sv]
// Types, character codes and limits for the method descriptor checker.
// Depends on nothing; imported by every module of the block.
package mdc_pkg;

   localparam logic [7:0] MAX_PARAMS     = 8'd255;
   localparam logic [7:0] MAX_ARRAY_DIMS = 8'd255;

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_J     = 8'h4A;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_ARRAY = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_V     = 8'h56;

   typedef enum logic [1:0] {
      PH_OPEN   = 2'd0,
      PH_PARAMS = 2'd1,
      PH_RETURN = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KIND_OPEN   = 3'd0,
      KIND_PRIM   = 3'd1,
      KIND_ARRAY  = 3'd2,
      KIND_CLASS  = 3'd3,
      KIND_SEMI   = 3'd4,
      KIND_CLOSE  = 3'd5,
      KIND_VOID   = 3'd6,
      KIND_REJECT = 3'd7
   } kind_type;

   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_NO_OPEN      = 4'd1;
   localparam logic [3:0] ERR_BAD_PARAM    = 4'd2;
   localparam logic [3:0] ERR_BAD_ELEM     = 4'd3;
   localparam logic [3:0] ERR_BAD_RETURN   = 4'd4;
   localparam logic [3:0] ERR_UNTERMINATED = 4'd5;
   localparam logic [3:0] ERR_TRAILING     = 4'd6;
   localparam logic [3:0] ERR_EARLY_END    = 4'd7;
   localparam logic [3:0] ERR_LIMIT        = 4'd8;

   typedef struct packed {
      logic is_open;
      logic is_close;
      logic is_prim;
      logic is_class;
      logic is_array;
      logic is_semi;
      logic is_void;
   } class_type;

   typedef struct packed {
      phase_type  phase;
      logic       in_class;
      logic [7:0] depth;
      logic [7:0] count;
      logic [3:0] err;
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic       complete;
      logic       in_return;
      logic [7:0] param_total;
      logic [3:0] error_code;
      logic       accepted;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:    PH_OPEN,
      in_class: 1'b0,
      depth:    8'd0,
      count:    8'd0,
      err:      ERR_NONE
   };

endpackage

[design/method_descriptor_checker.sv]
// Result: an accepted request's result is registered and appears on the rsp_ ports in the next cycle.
// Throughput: one request per cycle; the parser state register closes the loop
// each cycle and the single result register stalls requests only while held, apart from reset.
// Reset: synchronous, active high; parser returns to expect-open, result empty,
// requests stalled while reset is high.
// Depends on mdc_pkg, mdc_decode and mdc_next.
module method_descriptor_checker
   import mdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_byte_kind,
   output logic       rsp_type_complete,
   output logic       rsp_in_return,
   output logic [7:0] rsp_param_total,
   output logic [3:0] rsp_error_code,
   output logic       rsp_accepted
);

   state_type  state_ff, state_in;
   result_type result_ff, result_in;
   logic       valid_ff, valid_in;
   class_type  cls;
   logic       take;

   mdc_decode u_decode (
      .byte_in (req_byte_in),
      .cls     (cls)
   );

   mdc_next u_next (
      .cur         (state_ff),
      .cls         (cls),
      .end_of_text (req_end_of_text),
      .nxt         (state_in),
      .res         (result_in)
   );

   assign req_stall = reset | (valid_ff & rsp_stall);
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_byte_kind     = result_ff.kind;
   assign rsp_type_complete = result_ff.complete;
   assign rsp_in_return     = result_ff.in_return;
   assign rsp_param_total   = result_ff.param_total;
   assign rsp_error_code    = result_ff.error_code;
   assign rsp_accepted      = result_ff.accepted;

endmodule

[design/mdc_decode.sv]
// Byte classifier: flags which descriptor character a request byte is.
// Depends on mdc_pkg.
module mdc_decode
   import mdc_pkg::*;
(
   input  logic [7:0] byte_in,
   output class_type  cls
);

   always_comb begin
      cls          = '0;
      cls.is_open  = (byte_in == CH_OPEN);
      cls.is_close = (byte_in == CH_CLOSE);
      cls.is_class = (byte_in == CH_L);
      cls.is_array = (byte_in == CH_ARRAY);
      cls.is_semi  = (byte_in == CH_SEMI);
      cls.is_void  = (byte_in == CH_V);
      cls.is_prim  = (byte_in == CH_B) || (byte_in == CH_C) || (byte_in == CH_D) ||
                     (byte_in == CH_F) || (byte_in == CH_I) || (byte_in == CH_J) ||
                     (byte_in == CH_S) || (byte_in == CH_Z);
   end

endmodule

[design/mdc_next.sv]
// Grammar step: next parser state and the result fields for one byte.
// Depends on mdc_pkg; fed by mdc_decode.
module mdc_next
   import mdc_pkg::*;
(
   input  state_type  cur,
   input  class_type  cls,
   input  logic       end_of_text,
   output state_type  nxt,
   output result_type res
);

   logic     was_ret;
   logic     fin;
   kind_type fin_kind;

   always_comb begin
      nxt      = cur;
      res      = '0;
      res.kind = KIND_REJECT;
      was_ret  = 1'b0;
      fin      = 1'b0;
      fin_kind = KIND_PRIM;

      if (cur.err == ERR_NONE) begin
         was_ret = (cur.phase == PH_RETURN);
         if (cur.phase == PH_OPEN) begin
            if (cls.is_open) begin
               res.kind  = KIND_OPEN;
               nxt.phase = PH_PARAMS;
            end else begin
               nxt.err = ERR_NO_OPEN;
            end
         end else if (cur.phase == PH_DONE) begin
            nxt.err = ERR_TRAILING;
         end else if (cur.in_class) begin
            if (cls.is_semi) begin
               fin      = 1'b1;
               fin_kind = KIND_SEMI;
            end else begin
               res.kind = KIND_CLASS;
            end
         end else if (cls.is_prim) begin
            fin      = 1'b1;
            fin_kind = KIND_PRIM;
         end else if (cls.is_class) begin
            res.kind     = KIND_CLASS;
            nxt.in_class = 1'b1;
         end else if (cls.is_array) begin
            if (cur.depth >= MAX_ARRAY_DIMS) begin
               nxt.err = ERR_LIMIT;
            end else begin
               res.kind  = KIND_ARRAY;
               nxt.depth = cur.depth + 8'd1;
            end
         end else if (cur.depth != 8'd0) begin
            nxt.err = ERR_BAD_ELEM;
         end else if (cur.phase == PH_PARAMS) begin
            if (cls.is_close) begin
               res.kind  = KIND_CLOSE;
               nxt.phase = PH_RETURN;
               was_ret   = 1'b0;
            end else begin
               nxt.err = ERR_BAD_PARAM;
            end
         end else begin
            if (cls.is_void) begin
               res.kind     = KIND_VOID;
               res.complete = 1'b1;
               nxt.phase    = PH_DONE;
            end else begin
               nxt.err = ERR_BAD_RETURN;
            end
         end

         if (fin) begin
            if ((cur.phase == PH_PARAMS) && (cur.count >= MAX_PARAMS)) begin
               nxt.err = ERR_LIMIT;
            end else begin
               if (cur.phase == PH_PARAMS) begin
                  nxt.count = cur.count + 8'd1;
               end else begin
                  nxt.phase = PH_DONE;
               end
               res.kind     = fin_kind;
               res.complete = 1'b1;
               nxt.in_class = 1'b0;
               nxt.depth    = 8'd0;
            end
         end

         if (res.kind != KIND_REJECT) begin
            res.in_return = was_ret;
         end
      end

      res.param_total = nxt.count;

      if (end_of_text) begin
         if ((nxt.err == ERR_NONE) && (nxt.phase != PH_DONE)) begin
            nxt.err = nxt.in_class ? ERR_UNTERMINATED : ERR_EARLY_END;
         end
         res.accepted = (nxt.err == ERR_NONE);
      end
      res.error_code = nxt.err;

      if (end_of_text) begin
         nxt = STATE_RESET;
      end
   end

endmodule

[design/mdc_checker.sv]
// Port-level assertions for method_descriptor_checker, bound to the top level.
// Depends on mdc_pkg and method_descriptor_checker_assert.svh.
`include "method_descriptor_checker_assert.svh"

module mdc_checker
   import mdc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_byte_kind,
   input logic       rsp_type_complete,
   input logic       rsp_in_return,
   input logic [3:0] rsp_error_code,
   input logic       rsp_accepted
);

   `MDC_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid && !req_stall, rsp_valid)
   `MDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_byte_kind) && $stable(rsp_error_code) && $stable(rsp_accepted))
   `MDC_ASSERT_NOW(a_accept_clean, clock, reset, rsp_valid && rsp_accepted,
      rsp_error_code == ERR_NONE)
   `MDC_ASSERT_NOW(a_reject_quiet, clock, reset, rsp_valid && rsp_byte_kind == KIND_REJECT,
      !rsp_type_complete && !rsp_in_return)
   `MDC_ASSERT_NOW(a_complete_kind, clock, reset, rsp_valid && rsp_type_complete,
      rsp_byte_kind == KIND_PRIM || rsp_byte_kind == KIND_SEMI || rsp_byte_kind == KIND_VOID)

endmodule

bind method_descriptor_checker mdc_checker u_mdc_checker (.*);
